// File: rtl/tcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg
// Types and codes shared by the ternary cyclic convolution block.
// ----------------------------------------------------------------------------
package tcc_pkg;

    // Command codes carried on the op port.
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_APPLY = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    localparam int OP_W   = 2;
    localparam int IDX_IN_W = 10;
    localparam int VAL_W  = 16;
    localparam int TRIT_W = 2;
    localparam int COEF_W = 16;

    // Trit codes; any other nonzero code subtracts like minus one.
    localparam logic [TRIT_W-1:0] TRIT_ZERO = 2'd0;
    localparam logic [TRIT_W-1:0] TRIT_PLUS = 2'd1;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_APPLY = 5'b00100,
        S_FLUSH = 5'b01000,
        S_CLEAR = 5'b10000
    } state_t;

endpackage : tcc_pkg
`default_nettype wire

// File: rtl/ternary_cyclic_convolution_mod_q.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ternary_cyclic_convolution_mod_q
// Ternary-by-ring polynomial product in Z_q[x]/(x^N - 1), q = 2^LOG2_MODULUS.
// ----------------------------------------------------------------------------
// A word is accepted when start is high and busy is low; every word yields
// exactly one result word, shown for one cycle with done high. A read passes
// through the read state; an apply with a nonzero trit does one accumulator
// read-modify-write per cycle through a simple dual-port accumulator memory,
// then retires the last write in the flush state; a clear zeroes one
// accumulator entry per cycle. After reset the block runs the same clearing
// pass with busy high and no result word. Loads, applies with an out-of-range
// index or a zero trit, and reads with an out-of-range index finish straight
// from idle without raising busy. Results cannot be held off; the next word
// may be started in the same cycle a result is shown.
// ----------------------------------------------------------------------------
module ternary_cyclic_convolution_mod_q #(
    parameter int RING_DEGREE  = 509,
    parameter int LOG2_MODULUS = 11
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire tcc_pkg::op_t              op,
    input  wire logic [tcc_pkg::IDX_IN_W-1:0] index,
    input  wire logic [tcc_pkg::VAL_W-1:0] ring_value,
    input  wire logic [tcc_pkg::TRIT_W-1:0] trit,
    output logic                           done,
    output logic [tcc_pkg::COEF_W-1:0]     coefficient
);
    import tcc_pkg::*;

    // Address width of both memories; indexes below RING_DEGREE fit in it.
    localparam int IDX_W = (RING_DEGREE > 1) ? $clog2(RING_DEGREE) : 1;
    localparam int Q_W   = LOG2_MODULUS;
    localparam logic [IDX_IN_W:0] IDX_LIMIT = (IDX_IN_W+1)'(RING_DEGREE);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(RING_DEGREE - 1);

    // Storage: coefficients are kept reduced mod q, so only Q_W bits.
    logic [Q_W-1:0] opnd_mem [RING_DEGREE];
    logic [Q_W-1:0] acc_mem  [RING_DEGREE];

    state_t          state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;     // operand index j / clear pointer
    logic [IDX_W-1:0] k_reg, k_next;         // accumulator index (i + j) mod N
    logic            neg_reg, neg_next;      // subtract when set
    logic            init_reg, init_next;    // clearing pass after reset
    logic            wb_valid_reg, wb_valid_next;
    logic [IDX_W-1:0] wb_addr_reg, wb_addr_next;
    logic            done_reg, done_next;
    logic [COEF_W-1:0] coef_reg, coef_next;

    logic [Q_W-1:0]  acc_rdata_reg;
    logic [Q_W-1:0]  opnd_rdata_reg;

    logic            accept;
    logic            index_ok;
    logic [IDX_W-1:0] index_addr;

    logic            acc_rd_en;
    logic [IDX_W-1:0] acc_rd_addr;
    logic            acc_wr_en;
    logic [IDX_W-1:0] acc_wr_addr;
    logic [Q_W-1:0]  acc_wr_data;
    logic            opnd_wr_en;
    logic            opnd_rd_en;

    assign accept     = start && (state_reg == S_IDLE);
    assign index_ok   = ({1'b0, index} < IDX_LIMIT);
    assign index_addr = index[IDX_W-1:0];

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign coefficient = coef_reg;

    // ------------------------------------------------------------------
    // Memory port control
    // Apply is a two-deep pipe: read acc[k] and operand[j], then write
    // back acc[k] in the following cycle. The write address always trails the
    // read address by one ring step, so with N >= 2 the two never meet
    // and no forwarding is needed.
    // ------------------------------------------------------------------
    always_comb
    begin
        acc_rd_en   = 1'b0;
        acc_rd_addr = k_reg;
        opnd_rd_en  = 1'b0;
        opnd_wr_en  = 1'b0;
        acc_wr_en   = 1'b0;
        acc_wr_addr = wb_addr_reg;
        acc_wr_data = '0;

        if (state_reg == S_IDLE)
        begin
            acc_rd_addr = index_addr;
            acc_rd_en   = accept && (op == OP_READ) && index_ok;
            opnd_wr_en  = accept && (op == OP_LOAD) && index_ok;
        end
        else if (state_reg == S_APPLY)
        begin
            acc_rd_en  = 1'b1;
            opnd_rd_en = 1'b1;
        end

        if (state_reg == S_CLEAR)
        begin
            acc_wr_en   = 1'b1;
            acc_wr_addr = cnt_reg;
            acc_wr_data = '0;
        end
        else if (wb_valid_reg)
        begin
            acc_wr_en   = 1'b1;
            // Arithmetic wraps mod 2^Q_W, which is the reduction mod q.
            acc_wr_data = neg_reg ? (acc_rdata_reg - opnd_rdata_reg)
                                  : (acc_rdata_reg + opnd_rdata_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_wr_en)
        begin
            acc_mem[acc_wr_addr] <= acc_wr_data;
        end
        if (acc_rd_en)
        begin
            acc_rdata_reg <= acc_mem[acc_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (opnd_wr_en)
        begin
            opnd_mem[index_addr] <= ring_value[Q_W-1:0];
        end
        if (opnd_rd_en)
        begin
            opnd_rdata_reg <= opnd_mem[cnt_reg];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        neg_next      = neg_reg;
        init_next     = init_reg;
        wb_valid_next = (state_reg == S_APPLY);
        wb_addr_next  = k_reg;
        done_next     = 1'b0;
        coef_next     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_LOAD:
                        begin
                            done_next = 1'b1;
                        end
                        OP_APPLY:
                        begin
                            if (index_ok && (trit != TRIT_ZERO))
                            begin
                                state_next = S_APPLY;
                                cnt_next   = '0;
                                k_next     = index_addr;
                                neg_next   = (trit != TRIT_PLUS);
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (index_ok)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            state_next = S_CLEAR;
                            cnt_next   = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                coef_next  = COEF_W'(acc_rdata_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_APPLY:
            begin
                k_next = (k_reg == IDX_LAST) ? '0 : (k_reg + 1'b1);
                if (cnt_reg == IDX_LAST)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_FLUSH:
            begin
                // last write-back retires this cycle
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_CLEAR:
            begin
                if (cnt_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                    done_next  = !init_reg;
                    init_next  = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            k_reg        <= '0;
            neg_reg      <= 1'b0;
            init_reg     <= 1'b1;
            wb_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            k_reg        <= k_next;
            neg_reg      <= neg_next;
            init_reg     <= init_next;
            wb_valid_reg <= wb_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_addr_reg <= wb_addr_next;
        coef_reg    <= coef_next;
    end

`ifndef SYNTHESIS
    // A result is always a reduced coefficient.
    a_coef_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((coefficient >> LOG2_MODULUS) == '0))
        else $error("coefficient not reduced mod q");

    // Write-back never collides with a clearing write.
    a_wb_not_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> (state_reg != S_CLEAR))
        else $error("write-back during clear");

    // Read and write-back of the accumulator never hit the same entry.
    a_no_raw_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (wb_valid_reg && acc_rd_en) |-> (acc_rd_addr != wb_addr_reg))
        else $error("accumulator read/write address overlap");

    // A load raises done in the following cycle.
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_LOAD)) |=> done)
        else $error("load did not complete in one cycle");
`endif

endmodule : ternary_cyclic_convolution_mod_q
`default_nettype wire

// File: sim/tb_ternary_cyclic_convolution_mod_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ternary_cyclic_convolution_mod_q
// Self-checking bench for the ternary cyclic convolution block.
// ----------------------------------------------------------------------------
// A negedge driver feeds command words from a queue. A posedge monitor mirrors
// the operand store and the accumulator, predicts one coefficient per accepted
// word and compares each done strobe with the oldest prediction. Stimulus:
// accesses before the operand store is filled, a full operand fill, directed
// applies and reads on the ring edges, then a random mix with idle bursts.
// ----------------------------------------------------------------------------
module tb_ternary_cyclic_convolution_mod_q;
    import tcc_pkg::*;

    localparam int RING_DEGREE  = 509;
    localparam int LOG2_MODULUS = 11;
    localparam int RANDOM_WORDS = 218;
    localparam int MAX_REPORTS  = 10;

    // Minus one has two encodings; 3 is the alias.
    localparam logic [TRIT_W-1:0] TRIT_MINUS     = 2'd2;
    localparam logic [TRIT_W-1:0] TRIT_MINUS_ALT = 2'd3;

    localparam logic [COEF_W-1:0] COEF_MASK = COEF_W'((1 << LOG2_MODULUS) - 1);

    typedef struct {
        op_t                 op;
        logic [IDX_IN_W-1:0] index;
        logic [VAL_W-1:0]    ring_value;
        logic [TRIT_W-1:0]   trit;
    } cmd_word_t;

    typedef struct {
        cmd_word_t          word;
        logic [COEF_W-1:0]  coef;
    } coef_expect_t;

    // DUT ports; the inputs are known from time zero.
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                start      = 1'b0;
    logic                busy;
    op_t                 op         = OP_LOAD;
    logic [IDX_IN_W-1:0] index      = '0;
    logic [VAL_W-1:0]    ring_value = '0;
    logic [TRIT_W-1:0]   trit       = TRIT_ZERO;
    logic                done;
    logic [COEF_W-1:0]   coefficient;

    // Bench state.
    cmd_word_t         pending_words[$];
    coef_expect_t      coef_expected[$];
    logic [COEF_W-1:0] operand_mirror[RING_DEGREE];
    logic [COEF_W-1:0] acc_mirror[RING_DEGREE];
    bit                word_taken = 1'b0;
    int                idle_left  = 0;
    bit                idle_phase = 1'b0;
    int                words_sent = 0;
    int                mismatches = 0;

    ternary_cyclic_convolution_mod_q #(
        .RING_DEGREE  (RING_DEGREE),
        .LOG2_MODULUS (LOG2_MODULUS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .index       (index),
        .ring_value  (ring_value),
        .trit        (trit),
        .done        (done),
        .coefficient (coefficient)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction: one step of the ring product on the mirrored state. The
    // accumulator wraps at q, so every entry is already reduced.
    // ------------------------------------------------------------------------
    function automatic logic [COEF_W-1:0] convolve_step(input cmd_word_t w);
        logic [COEF_W-1:0] coef;
        int                k;
        int                j;
        coef = '0;
        case (w.op)
            OP_LOAD:
            begin
                if (w.index < RING_DEGREE)
                    operand_mirror[w.index] = w.ring_value & COEF_MASK;
            end
            OP_APPLY:
            begin
                if (w.index < RING_DEGREE && w.trit != TRIT_ZERO)
                begin
                    k = int'(w.index);
                    for (j = 0; j < RING_DEGREE; j++)
                    begin
                        // trit 2 and trit 3 both subtract
                        if (w.trit == TRIT_PLUS)
                            acc_mirror[k] = (acc_mirror[k] + operand_mirror[j]) & COEF_MASK;
                        else
                            acc_mirror[k] = (acc_mirror[k] - operand_mirror[j]) & COEF_MASK;
                        k = (k + 1 == RING_DEGREE) ? 0 : k + 1;
                    end
                end
            end
            OP_READ:
            begin
                if (w.index < RING_DEGREE)
                    coef = acc_mirror[w.index] & COEF_MASK;
            end
            default:
            begin
                for (j = 0; j < RING_DEGREE; j++)
                    acc_mirror[j] = '0;
            end
        endcase
        return coef;
    endfunction

    function automatic cmd_word_t make_word(input op_t o, input int idx, input int val,
                                            input logic [TRIT_W-1:0] t);
        cmd_word_t w;
        w.op         = o;
        w.index      = IDX_IN_W'(idx);
        w.ring_value = VAL_W'(val);
        w.trit       = t;
        return w;
    endfunction

    // Mostly in range; one in ten lands at or above the ring degree.
    function automatic int pick_index();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(RING_DEGREE, (1 << IDX_IN_W) - 1);
        return $urandom_range(0, RING_DEGREE - 1);
    endfunction

    function automatic logic [TRIT_W-1:0] pick_trit();
        case ($urandom_range(0, 9))
            0:       return TRIT_ZERO;
            1:       return TRIT_MINUS_ALT;
            2, 3, 4: return TRIT_MINUS;
            default: return TRIT_PLUS;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: changes inputs on the falling edge. A word stays up until the
    // rising edge that takes it; then an idle gap may follow, drawn per word
    // while an idle burst is on.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        cmd_word_t w;
        if (rst_n && (!start || word_taken))
        begin
            if (idle_left > 0)
            begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (pending_words.size() > 0)
            begin
                w          = pending_words.pop_front();
                start      <= 1'b1;
                op         <= w.op;
                index      <= w.index;
                ring_value <= w.ring_value;
                trit       <= w.trit;
                words_sent <= words_sent + 1;
                // switch between busy-idle and back-to-back stretches
                if (words_sent % 40 == 39)
                    idle_phase <= ($urandom_range(0, 2) != 0);
                idle_left  <= idle_phase ? $urandom_range(0, 5) : 0;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks the result of an earlier word first, then predicts the
    // word taken at this edge. A result shown in the acceptance cycle of the
    // next word therefore still pairs with the older prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        coef_expect_t e;
        cmd_word_t    w;
        if (rst_n)
        begin
            if (done)
            begin
                if (coef_expected.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result word, coefficient %h",
                                 $realtime, coefficient);
                end
                else
                begin
                    e = coef_expected.pop_front();
                    if (coefficient !== e.coef)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: %s index %0d trit %0d: coefficient exp %h got %h",
                                     $realtime, e.word.op.name(), e.word.index, e.word.trit,
                                     e.coef, coefficient);
                    end
                end
            end
            if (start && !busy)
            begin
                w.op         = op;
                w.index      = index;
                w.ring_value = ring_value;
                w.trit       = trit;
                e.word       = w;
                e.coef       = convolve_step(w);
                coef_expected.push_back(e);
            end
        end
        word_taken <= rst_n && start && !busy;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        int r;
        for (n = 0; n < RING_DEGREE; n++)
        begin
            operand_mirror[n] = '0;
            acc_mirror[n]     = '0;
        end

        // Before the operand store holds anything: reads of the cleared
        // accumulator, zero-trit and out-of-range applies, ignored loads, a clear.
        pending_words.push_back(make_word(OP_READ, 0, 0, TRIT_ZERO));
        pending_words.push_back(make_word(OP_READ, RING_DEGREE - 1, 16'hFFFF, TRIT_MINUS_ALT));
        pending_words.push_back(make_word(OP_READ, RING_DEGREE, 0, TRIT_ZERO));
        pending_words.push_back(make_word(OP_READ, 1023, 0, TRIT_ZERO));
        pending_words.push_back(make_word(OP_APPLY, 0, 0, TRIT_ZERO));
        pending_words.push_back(make_word(OP_APPLY, 1023, 0, TRIT_PLUS));
        pending_words.push_back(make_word(OP_LOAD, RING_DEGREE, 16'hFFFF, TRIT_ZERO));
        pending_words.push_back(make_word(OP_LOAD, 1023, 16'h1234, TRIT_ZERO));
        pending_words.push_back(make_word(OP_CLEAR, 0, 0, TRIT_ZERO));

        // Every operand entry has to be written before the first real apply.
        for (n = 0; n < RING_DEGREE; n++)
        begin
            if (n == 0)
                r = 16'hFFFF;
            else if (n == RING_DEGREE - 1)
                r = 0;
            else if (n == 1)
                r = 16'h07FF;
            else
                r = $urandom_range(0, 16'hFFFF);
            pending_words.push_back(make_word(OP_LOAD, n, r, TRIT_ZERO));
        end

        // Applies at both ends of the ring (wraparound), both minus codes.
        pending_words.push_back(make_word(OP_APPLY, 0, 0, TRIT_PLUS));
        pending_words.push_back(make_word(OP_APPLY, RING_DEGREE - 1, 0, TRIT_MINUS));
        pending_words.push_back(make_word(OP_APPLY, 1, 0, TRIT_MINUS_ALT));
        pending_words.push_back(make_word(OP_APPLY, 1023, 0, TRIT_MINUS));
        pending_words.push_back(make_word(OP_APPLY, 5, 0, TRIT_ZERO));
        pending_words.push_back(make_word(OP_READ, 0, 0, TRIT_ZERO));
        pending_words.push_back(make_word(OP_READ, RING_DEGREE - 1, 0, TRIT_ZERO));
        pending_words.push_back(make_word(OP_READ, 1, 0, TRIT_ZERO));
        pending_words.push_back(make_word(OP_READ, RING_DEGREE, 0, TRIT_ZERO));
        pending_words.push_back(make_word(OP_READ, 1023, 0, TRIT_ZERO));
        // Clear keeps the operands; the apply after it starts from zero.
        pending_words.push_back(make_word(OP_CLEAR, 0, 0, TRIT_ZERO));
        pending_words.push_back(make_word(OP_READ, 0, 0, TRIT_ZERO));
        pending_words.push_back(make_word(OP_APPLY, RING_DEGREE - 1, 0, TRIT_PLUS));
        pending_words.push_back(make_word(OP_READ, RING_DEGREE - 2, 0, TRIT_ZERO));

        // Random mix: applies and reads dominate, operand rewrites in between,
        // an occasional clear.
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            r = $urandom_range(0, 19);
            if (r < 6)
                pending_words.push_back(make_word(OP_LOAD, pick_index(),
                                                  $urandom_range(0, 16'hFFFF), pick_trit()));
            else if (r < 11)
                pending_words.push_back(make_word(OP_APPLY, pick_index(),
                                                  $urandom_range(0, 16'hFFFF), pick_trit()));
            else if (r < 19)
                pending_words.push_back(make_word(OP_READ, pick_index(),
                                                  $urandom_range(0, 16'hFFFF), pick_trit()));
            else
                pending_words.push_back(make_word(OP_CLEAR, pick_index(),
                                                  $urandom_range(0, 16'hFFFF), pick_trit()));
        end

        // Reset, released on a falling edge away from the sampling edge. The
        // block then runs its own clearing pass with busy high.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() > 0 || start)
            @(posedge clk);
        while (coef_expected.size() > 0)
            @(posedge clk);
        // Room for a stray result after the last expected one.
        repeat (RING_DEGREE + 16) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Worst case is about 750 words, some 0.8 ms.
    initial
    begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
